// ===== hdl/pv2hp_pkg.sv =====
// ----------------------------------------------------------------------------
// pv2hp_pkg
// Shared types and constants for the PROXY v2 header parser.
// ----------------------------------------------------------------------------
package pv2hp_pkg;

  // Width of the protocol level register.
  localparam int unsigned LevelWidth = 4;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  // Input action codes.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_EOS   = 2'd2;

  // Protocol levels.
  localparam logic [LevelWidth-1:0] LEVEL_OFF = 4'd0;
  localparam logic [LevelWidth-1:0] LEVEL_V2  = 4'd2;

  // Fixed header layout.
  localparam logic [15:0] SIG_LEN   = 16'd12;
  localparam logic [15:0] IDX_VCMD  = 16'd12;
  localparam logic [15:0] IDX_FAM   = 16'd13;
  localparam logic [15:0] IDX_LENHI = 16'd14;
  localparam logic [15:0] IDX_LENLO = 16'd15;

  // Version nibble and command codes.
  localparam logic [3:0] VERSION_2 = 4'h2;
  localparam logic [3:0] CMD_LOCAL = 4'h0;
  localparam logic [3:0] CMD_PROXY = 4'h1;

  // Address family nibbles and their required body lengths.
  localparam logic [3:0]  FAM_IPV4 = 4'h1;
  localparam logic [3:0]  FAM_IPV6 = 4'h2;
  localparam logic [3:0]  FAM_UNIX = 4'h3;
  localparam logic [15:0] LEN_IPV4 = 16'd12;
  localparam logic [15:0] LEN_IPV6 = 16'd36;
  localparam logic [15:0] LEN_UNIX = 16'd216;

  // Body offsets of the address and port bytes.
  localparam logic [15:0] V4_ADDR_BYTES = 16'd4;
  localparam logic [15:0] V4_PORT_HI    = 16'd8;
  localparam logic [15:0] V4_PORT_LO    = 16'd9;
  localparam logic [15:0] V6_HIGH_BYTES = 16'd8;
  localparam logic [15:0] V6_ADDR_BYTES = 16'd16;
  localparam logic [15:0] V6_PORT_HI    = 16'd32;
  localparam logic [15:0] V6_PORT_LO    = 16'd33;

  // Result kinds.
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_PATH    = 1'b1;

  // Verdict codes.
  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_LOCAL    = 3'd1,
    ST_IPV4     = 3'd2,
    ST_IPV6     = 3'd3,
    ST_UNIX     = 3'd4,
    ST_OTHER    = 3'd5,
    ST_ERROR    = 3'd6
  } status_e;

  // Command classes produced by the front part.
  typedef enum logic [2:0] {
    CLS_START_OFF,
    CLS_START_BAD,
    CLS_START_PARSE,
    CLS_DATA,
    CLS_EOS
  } cls_e;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_e;

  // One queued command.
  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic        kind;
    status_e     status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
    logic [7:0]  path_byte;
    logic [6:0]  path_index;
  } res_t;

  // Expected signature byte at a header position.
  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h0d;
      4'd1:    val = 8'h0a;
      4'd2:    val = 8'h0d;
      4'd3:    val = 8'h0a;
      4'd4:    val = 8'h00;
      4'd5:    val = 8'h0d;
      4'd6:    val = 8'h0a;
      4'd7:    val = 8'h51;
      4'd8:    val = 8'h55;
      4'd9:    val = 8'h49;
      4'd10:   val = 8'h54;
      4'd11:   val = 8'h0a;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/pv2hp_front.sv =====
// ----------------------------------------------------------------------------
// pv2hp_front
// Holds the protocol level and classifies incoming words for the back part.
// ----------------------------------------------------------------------------
module pv2hp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pv2hp_pkg::LevelWidth-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic [1:0]                          action_i,
  input  logic [7:0]                          data_byte_i,
  input  logic                                q_full_i,
  output logic                                in_stall_o,
  output logic                                push_o,
  output pv2hp_pkg::cmd_t                     cmd_o
);

  logic [pv2hp_pkg::LevelWidth-1:0] level_q;
  logic                             keep;

  // Protocol level register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= pv2hp_pkg::LEVEL_OFF;
    end else if (cfg_we_i) begin
      level_q <= cfg_wdata_i;
    end
  end

  // Classify the word; a start resolves the level right here.
  always_comb begin
    keep         = 1'b1;
    cmd_o.data   = data_byte_i;
    cmd_o.cls    = pv2hp_pkg::CLS_DATA;
    case (action_i)
      pv2hp_pkg::ACT_START: begin
        if (level_q == pv2hp_pkg::LEVEL_OFF) begin
          cmd_o.cls = pv2hp_pkg::CLS_START_OFF;
        end else if (level_q == pv2hp_pkg::LEVEL_V2) begin
          cmd_o.cls = pv2hp_pkg::CLS_START_PARSE;
        end else begin
          cmd_o.cls = pv2hp_pkg::CLS_START_BAD;
        end
      end
      pv2hp_pkg::ACT_DATA: begin
        cmd_o.cls = pv2hp_pkg::CLS_DATA;
      end
      pv2hp_pkg::ACT_EOS: begin
        cmd_o.cls = pv2hp_pkg::CLS_EOS;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Words with an unused action code are accepted and dropped.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

// ===== hdl/pv2hp_queue.sv =====
// ----------------------------------------------------------------------------
// pv2hp_queue
// Small FIFO of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
module pv2hp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pv2hp_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output pv2hp_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = pv2hp_pkg::QueuePtrWidth;

  pv2hp_pkg::cmd_t            store_q [pv2hp_pkg::QueueDepth];
  logic [PtrW-1:0]            wr_ptr_q;
  logic [PtrW-1:0]            rd_ptr_q;
  logic [PtrW:0]              count_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign full_o  = (count_q == (PtrW+1)'(pv2hp_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = store_q[rd_ptr_q];

endmodule

// ===== hdl/pv2hp_back.sv =====
// ----------------------------------------------------------------------------
// pv2hp_back
// Header and body parser; executes one queued command per cycle unless the
// held result is stalled, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module pv2hp_back #(
  parameter int unsigned UNIX_PATH_BYTES = 108
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  pv2hp_pkg::cmd_t cmd_i,
  output logic            pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output pv2hp_pkg::res_t res_o
);

  pv2hp_pkg::phase_e phase_q, phase_d;
  logic [15:0]       cnt_q, cnt_d;
  logic              sig_ok_q, sig_ok_d;
  logic [7:0]        vcmd_q, vcmd_d;
  logic [3:0]        fam_q, fam_d;
  logic [15:0]       len_q, len_d;
  logic [63:0]       addr_hi_q, addr_hi_d;
  logic [63:0]       addr_lo_q, addr_lo_d;
  logic [15:0]       port_q, port_d;

  logic              out_vld_q;
  pv2hp_pkg::res_t   res_q;
  logic              can_take;
  logic              res_vld;
  pv2hp_pkg::res_t   res_d;
  logic [15:0]       len_new;
  logic [7:0]        b;
  logic [16:0]       cnt_inc;

  // A command runs when the output register is free or being drained.
  assign can_take = !out_vld_q || !out_stall_i;
  assign pop_o    = q_valid_i && can_take;
  assign b        = cmd_i.data;
  assign len_new  = {len_q[15:8], b};
  assign cnt_inc  = {1'b0, cnt_q} + 17'd1;

  // Parser next state and result.
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    sig_ok_d   = sig_ok_q;
    vcmd_d     = vcmd_q;
    fam_d      = fam_q;
    len_d      = len_q;
    addr_hi_d  = addr_hi_q;
    addr_lo_d  = addr_lo_q;
    port_d     = port_q;
    res_vld    = 1'b0;
    res_d      = '0;
    res_d.kind = pv2hp_pkg::KIND_VERDICT;
    res_d.status = pv2hp_pkg::ST_ERROR;

    if (pop_o) begin
      case (cmd_i.cls)
        pv2hp_pkg::CLS_START_OFF, pv2hp_pkg::CLS_START_BAD,
        pv2hp_pkg::CLS_START_PARSE: begin
          cnt_d     = '0;
          sig_ok_d  = 1'b1;
          vcmd_d    = '0;
          fam_d     = '0;
          len_d     = '0;
          addr_hi_d = '0;
          addr_lo_d = '0;
          port_d    = '0;
          if (cmd_i.cls == pv2hp_pkg::CLS_START_PARSE) begin
            phase_d = pv2hp_pkg::PH_HEADER;
          end else begin
            phase_d = pv2hp_pkg::PH_DONE;
            res_vld = 1'b1;
            res_d.status = (cmd_i.cls == pv2hp_pkg::CLS_START_OFF) ?
                           pv2hp_pkg::ST_DISABLED : pv2hp_pkg::ST_ERROR;
          end
        end

        pv2hp_pkg::CLS_EOS: begin
          // End of stream inside a header or body is an error.
          if (phase_q == pv2hp_pkg::PH_HEADER || phase_q == pv2hp_pkg::PH_BODY) begin
            phase_d      = pv2hp_pkg::PH_DONE;
            res_vld      = 1'b1;
            res_d.status = pv2hp_pkg::ST_ERROR;
          end
        end

        pv2hp_pkg::CLS_DATA: begin
          case (phase_q)
            pv2hp_pkg::PH_HEADER: begin
              cnt_d = cnt_inc[15:0];
              if (cnt_q < pv2hp_pkg::SIG_LEN) begin
                if (b != pv2hp_pkg::sig_byte(cnt_q[3:0])) begin
                  sig_ok_d = 1'b0;
                end
              end else if (cnt_q == pv2hp_pkg::IDX_VCMD) begin
                vcmd_d = b;
              end else if (cnt_q == pv2hp_pkg::IDX_FAM) begin
                fam_d = b[7:4];
              end else if (cnt_q == pv2hp_pkg::IDX_LENHI) begin
                len_d = {b, 8'h00};
              end else begin
                len_d = len_new;
              end

              // Verdict on the fixed header after its last byte.
              if (cnt_q == pv2hp_pkg::IDX_LENLO) begin
                res_vld = 1'b1;
                phase_d = pv2hp_pkg::PH_DONE;
                if (!sig_ok_q || vcmd_q[7:4] != pv2hp_pkg::VERSION_2) begin
                  res_d.status = pv2hp_pkg::ST_ERROR;
                end else if (vcmd_q[3:0] == pv2hp_pkg::CMD_LOCAL) begin
                  res_d.status = pv2hp_pkg::ST_LOCAL;
                end else if (vcmd_q[3:0] != pv2hp_pkg::CMD_PROXY) begin
                  res_d.status = pv2hp_pkg::ST_ERROR;
                end else if ((fam_q == pv2hp_pkg::FAM_IPV4 && len_new != pv2hp_pkg::LEN_IPV4) ||
                             (fam_q == pv2hp_pkg::FAM_IPV6 && len_new != pv2hp_pkg::LEN_IPV6) ||
                             (fam_q == pv2hp_pkg::FAM_UNIX && len_new != pv2hp_pkg::LEN_UNIX)) begin
                  res_d.status = pv2hp_pkg::ST_ERROR;
                end else if (fam_q != pv2hp_pkg::FAM_IPV4 && fam_q != pv2hp_pkg::FAM_IPV6 &&
                             fam_q != pv2hp_pkg::FAM_UNIX && len_new == 16'd0) begin
                  res_d.status = pv2hp_pkg::ST_OTHER;
                end else begin
                  res_vld = 1'b0;
                  phase_d = pv2hp_pkg::PH_BODY;
                  cnt_d   = '0;
                end
              end
            end

            pv2hp_pkg::PH_BODY: begin
              cnt_d = cnt_inc[15:0];
              if (fam_q == pv2hp_pkg::FAM_IPV4) begin
                if (cnt_q < pv2hp_pkg::V4_ADDR_BYTES) begin
                  addr_lo_d = {addr_lo_q[55:0], b};
                end
                if (cnt_q == pv2hp_pkg::V4_PORT_HI || cnt_q == pv2hp_pkg::V4_PORT_LO) begin
                  port_d = {port_q[7:0], b};
                end
                if (cnt_inc[15:0] == pv2hp_pkg::LEN_IPV4) begin
                  phase_d         = pv2hp_pkg::PH_DONE;
                  res_vld         = 1'b1;
                  res_d.status    = pv2hp_pkg::ST_IPV4;
                  res_d.addr_low  = {32'h0, addr_lo_q[31:0]};
                  res_d.port      = port_q;
                end
              end else if (fam_q == pv2hp_pkg::FAM_IPV6) begin
                if (cnt_q < pv2hp_pkg::V6_HIGH_BYTES) begin
                  addr_hi_d = {addr_hi_q[55:0], b};
                end else if (cnt_q < pv2hp_pkg::V6_ADDR_BYTES) begin
                  addr_lo_d = {addr_lo_q[55:0], b};
                end
                if (cnt_q == pv2hp_pkg::V6_PORT_HI || cnt_q == pv2hp_pkg::V6_PORT_LO) begin
                  port_d = {port_q[7:0], b};
                end
                if (cnt_inc[15:0] == pv2hp_pkg::LEN_IPV6) begin
                  phase_d         = pv2hp_pkg::PH_DONE;
                  res_vld         = 1'b1;
                  res_d.status    = pv2hp_pkg::ST_IPV6;
                  res_d.addr_high = addr_hi_q;
                  res_d.addr_low  = addr_lo_q;
                  res_d.port      = port_q;
                end
              end else if (fam_q == pv2hp_pkg::FAM_UNIX) begin
                // Leading path bytes go out one by one; the rest are consumed.
                if (cnt_inc[15:0] == pv2hp_pkg::LEN_UNIX) begin
                  phase_d      = pv2hp_pkg::PH_DONE;
                  res_vld      = 1'b1;
                  res_d.status = pv2hp_pkg::ST_UNIX;
                end else if (cnt_q < 16'(UNIX_PATH_BYTES)) begin
                  res_vld          = 1'b1;
                  res_d.kind       = pv2hp_pkg::KIND_PATH;
                  res_d.status     = pv2hp_pkg::ST_UNIX;
                  res_d.path_byte  = b;
                  res_d.path_index = cnt_q[6:0];
                end
              end else begin
                // Unknown family: skip the body.
                if (cnt_inc >= {1'b0, len_q}) begin
                  phase_d      = pv2hp_pkg::PH_DONE;
                  res_vld      = 1'b1;
                  res_d.status = pv2hp_pkg::ST_OTHER;
                end
              end
            end

            default: begin
            end
          endcase
        end

        default: begin
        end
      endcase
    end
  end

  // Parser control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pv2hp_pkg::PH_IDLE;
      cnt_q    <= '0;
      sig_ok_q <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      sig_ok_q <= sig_ok_d;
    end
  end

  // Parser payload state.
  always_ff @(posedge clk_i) begin
    vcmd_q    <= vcmd_d;
    fam_q     <= fam_d;
    len_q     <= len_d;
    addr_hi_q <= addr_hi_d;
    addr_lo_q <= addr_lo_d;
    port_q    <= port_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (can_take) begin
      out_vld_q <= pop_o && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_vld) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/proxy_v2_header_parser.sv =====
// ----------------------------------------------------------------------------
// proxy_v2_header_parser
// PROXY protocol v2 header parser with a classifying front, a command queue
// and a parsing back end.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one word per accepted cycle (start of a
// connection, one stream byte, or end of stream). The output channel gives
// zero or one result word per input word: Unix path bytes and one final
// verdict per connection, with the source address and port for IPv4/IPv6.
// protocol_level is to be written through cfg_we_i/cfg_wdata_i only while
// idle; the block does not enforce this. It is sampled when a start word is
// accepted. Throughput is one input word per cycle while the queue is not
// full. The front classifies in the accept cycle, the word is registered in
// the four-entry queue, and the back parser runs it and registers the result
// in the output register, which drives out_valid_o.
// Reset clears the queue, the output register and the parser to idle, and
// sets the level to 0. When the receiver stalls, the result is held in the
// output register, the back stops draining, and in_stall_o rises once the
// queue is full.
// ----------------------------------------------------------------------------
module proxy_v2_header_parser #(
  parameter int unsigned UNIX_PATH_BYTES = 108
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [2:0]  status_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o,
  output logic [15:0] source_port_o,
  output logic [7:0]  path_byte_o,
  output logic [6:0]  path_index_o
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;
  pv2hp_pkg::cmd_t front_cmd;
  pv2hp_pkg::cmd_t queue_cmd;
  pv2hp_pkg::res_t res;

  // Front: level register and word classification.
  pv2hp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  // Queue between the two sides.
  pv2hp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd)
  );

  // Back: parser and output register.
  pv2hp_back #(
    .UNIX_PATH_BYTES (UNIX_PATH_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign result_kind_o = res.kind;
  assign status_o      = res.status;
  assign addr_high_o   = res.addr_high;
  assign addr_low_o    = res.addr_low;
  assign source_port_o = res.port;
  assign path_byte_o   = res.path_byte;
  assign path_index_o  = res.path_index;

endmodule

// ===== dv/pv2hp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pv2hp_checker
// Watches the configuration port and both channels of the PROXY v2 header
// parser. It tracks the parse state of the current connection on its own,
// queues the word that each accepted input word should produce, and checks
// every accepted result word, field by field, against the oldest entry.
// ----------------------------------------------------------------------------
module pv2hp_checker
  import pv2hp_pkg::*;
#(
  parameter int unsigned UNIX_PATH_BYTES = 108
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        result_kind_i,
  input  logic [2:0]  status_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [15:0] source_port_i,
  input  logic [7:0]  path_byte_i,
  input  logic [6:0]  path_index_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  // The fixed 12-byte signature that opens every v2 header.
  localparam logic [7:0] Signature [12] = '{
    8'h0d, 8'h0a, 8'h0d, 8'h0a, 8'h00, 8'h0d, 8'h0a, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0a
  };

  // Parse state of the connection in progress.
  logic [3:0]  level_q;
  phase_e      phase_q;
  logic [15:0] count_q;
  logic        sig_ok_q;
  logic [7:0]  ver_cmd_q;
  logic [7:0]  family_q;
  logic [15:0] body_len_q;
  logic [63:0] acc_high_q;
  logic [63:0] acc_low_q;
  logic [15:0] port_acc_q;

  res_t        pending_results[$];
  int unsigned errs;

  function automatic void restart_parse();
    phase_q    = PH_IDLE;
    count_q    = '0;
    sig_ok_q   = 1'b1;
    ver_cmd_q  = '0;
    family_q   = '0;
    body_len_q = '0;
    acc_high_q = '0;
    acc_low_q  = '0;
    port_acc_q = '0;
  endfunction

  // A verdict ends the connection; later words are ignored until a start.
  function automatic res_t close_run(input status_e st);
    res_t r;
    r        = '0;
    r.kind   = KIND_VERDICT;
    r.status = st;
    phase_q  = PH_DONE;
    return r;
  endfunction

  // Decide the fate of the connection once all 16 fixed header bytes are in.
  function automatic bit end_of_header(output res_t r);
    logic [3:0] fam;
    fam = family_q[7:4];
    r   = '0;
    if (!sig_ok_q || ver_cmd_q[7:4] != VERSION_2) begin
      r = close_run(ST_ERROR);
      return 1'b1;
    end
    if (ver_cmd_q[3:0] == CMD_LOCAL) begin
      r = close_run(ST_LOCAL);
      return 1'b1;
    end
    if (ver_cmd_q[3:0] != CMD_PROXY) begin
      r = close_run(ST_ERROR);
      return 1'b1;
    end
    if ((fam == FAM_IPV4 && body_len_q != LEN_IPV4) ||
        (fam == FAM_IPV6 && body_len_q != LEN_IPV6) ||
        (fam == FAM_UNIX && body_len_q != LEN_UNIX)) begin
      r = close_run(ST_ERROR);
      return 1'b1;
    end
    if (fam != FAM_IPV4 && fam != FAM_IPV6 && fam != FAM_UNIX && body_len_q == 0) begin
      r = close_run(ST_OTHER);
      return 1'b1;
    end
    phase_q = PH_BODY;
    count_q = '0;
    return 1'b0;
  endfunction

  // One body byte: gather address and port, or pass on a Unix path byte.
  function automatic bit body_word(input logic [7:0] b, output res_t r);
    logic [3:0]  fam;
    logic [15:0] idx;
    fam     = family_q[7:4];
    idx     = count_q;
    count_q = count_q + 16'd1;
    r       = '0;
    if (fam == FAM_IPV4) begin
      if (idx < V4_ADDR_BYTES) acc_low_q = {acc_low_q[55:0], b};
      if (idx == V4_PORT_HI || idx == V4_PORT_LO) port_acc_q = {port_acc_q[7:0], b};
      if (count_q == LEN_IPV4) begin
        r          = close_run(ST_IPV4);
        r.addr_low = {32'h0, acc_low_q[31:0]};
        r.port     = port_acc_q;
        return 1'b1;
      end
      return 1'b0;
    end
    if (fam == FAM_IPV6) begin
      if (idx < V6_HIGH_BYTES) acc_high_q = {acc_high_q[55:0], b};
      else if (idx < V6_ADDR_BYTES) acc_low_q = {acc_low_q[55:0], b};
      if (idx == V6_PORT_HI || idx == V6_PORT_LO) port_acc_q = {port_acc_q[7:0], b};
      if (count_q == LEN_IPV6) begin
        r           = close_run(ST_IPV6);
        r.addr_high = acc_high_q;
        r.addr_low  = acc_low_q;
        r.port      = port_acc_q;
        return 1'b1;
      end
      return 1'b0;
    end
    if (fam == FAM_UNIX) begin
      if (count_q == LEN_UNIX) begin
        r = close_run(ST_UNIX);
        return 1'b1;
      end
      if (idx < UNIX_PATH_BYTES) begin
        r.kind       = KIND_PATH;
        r.status     = ST_UNIX;
        r.path_byte  = b;
        r.path_index = idx[6:0];
        return 1'b1;
      end
      return 1'b0;
    end
    // Any other family: the body is only counted off.
    if (count_q >= body_len_q) begin
      r = close_run(ST_OTHER);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the parse by one input word; returns 1 when a result is due.
  function automatic bit parse_word(input logic [1:0] act, input logic [7:0] b,
                                    output res_t r);
    logic [15:0] idx;
    r = '0;
    if (act == ACT_START) begin
      restart_parse();
      if (level_q == LEVEL_OFF) begin
        r = close_run(ST_DISABLED);
        return 1'b1;
      end
      if (level_q != LEVEL_V2) begin
        r = close_run(ST_ERROR);
        return 1'b1;
      end
      phase_q = PH_HEADER;
      return 1'b0;
    end
    if (act == ACT_EOS) begin
      if (phase_q == PH_HEADER || phase_q == PH_BODY) begin
        r = close_run(ST_ERROR);
        return 1'b1;
      end
      return 1'b0;
    end
    if (act != ACT_DATA) return 1'b0;
    if (phase_q == PH_HEADER) begin
      idx = count_q;
      if (idx < SIG_LEN) begin
        if (b != Signature[idx[3:0]]) sig_ok_q = 1'b0;
      end else if (idx == IDX_VCMD) begin
        ver_cmd_q = b;
      end else if (idx == IDX_FAM) begin
        family_q = b;
      end else if (idx == IDX_LENHI) begin
        body_len_q = {b, 8'h00};
      end else begin
        body_len_q = body_len_q | {8'h00, b};
      end
      count_q = count_q + 16'd1;
      if (count_q == 16'd16) return end_of_header(r);
      return 1'b0;
    end
    if (phase_q == PH_BODY) return body_word(b, r);
    return 1'b0;
  endfunction

  function automatic int unsigned field_check(input string name, input logic [63:0] want,
                                              input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Input words are predicted before result words are checked in each cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t predicted;
    if (!rst_ni) begin
      level_q = LEVEL_OFF;
      restart_parse();
      pending_results.delete();
      errs = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) level_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (parse_word(action_i, data_byte_i, predicted)) pending_results.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("Result word with nothing expected: kind %0d, status %0d",
                 result_kind_i, status_i);
          errs++;
        end else begin
          predicted = pending_results.pop_front();
          errs += field_check("result_kind", predicted.kind, result_kind_i);
          errs += field_check("status", predicted.status, status_i);
          errs += field_check("addr_high", predicted.addr_high, addr_high_i);
          errs += field_check("addr_low", predicted.addr_low, addr_low_i);
          errs += field_check("source_port", predicted.port, source_port_i);
          errs += field_check("path_byte", predicted.path_byte, path_byte_i);
          errs += field_check("path_index", predicted.path_index, path_index_i);
        end
      end
      pending_o <= pending_results.size();
      err_cnt_o <= errs;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives connections into the PROXY v2 header parser: a short directed run of
// corner cases, then random phases at changing protocol levels with well-formed
// IPv4, IPv6, Unix, LOCAL and other-family headers, broken headers, streams cut
// short and plain noise. Both sides idle at random; the checker beside the
// parser predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import pv2hp_pkg::*;

  localparam int unsigned UnixPathBytes = 108;
  localparam int unsigned ItemTarget    = 700;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned NoFault       = 12;
  localparam int unsigned HeaderBytes   = 16;

  // Action code with no meaning; the parser must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] TailActs [3] = '{ACT_DATA, ACT_EOS, ACT_UNUSED};

  typedef enum {
    CONN_IPV4,
    CONN_IPV6,
    CONN_UNIX,
    CONN_LOCAL,
    CONN_OTHER,
    CONN_BAD_HEADER,
    CONN_CUT,
    CONN_NOISE
  } conn_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        result_kind_o;
  logic [2:0]  status_o;
  logic [63:0] addr_high_o;
  logic [63:0] addr_low_o;
  logic [15:0] source_port_o;
  logic [7:0]  path_byte_o;
  logic [6:0]  path_index_o;

  int unsigned err_cnt;
  int unsigned pending_cnt;
  int unsigned sent;
  int unsigned hold_reqs;
  logic        calm;

  proxy_v2_header_parser #(
    .UNIX_PATH_BYTES(UnixPathBytes)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .status_o     (status_o),
    .addr_high_o  (addr_high_o),
    .addr_low_o   (addr_low_o),
    .source_port_o(source_port_o),
    .path_byte_o  (path_byte_o),
    .path_index_o (path_index_o)
  );

  pv2hp_checker #(
    .UNIX_PATH_BYTES(UnixPathBytes)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_i(result_kind_o),
    .status_i     (status_o),
    .addr_high_i  (addr_high_o),
    .addr_low_i   (addr_low_o),
    .source_port_i(source_port_o),
    .path_byte_i  (path_byte_o),
    .path_index_i (path_index_o),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a result never shows up.
  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 11);
      end
    end
  end

  // Offer one word, possibly after a few idle cycles, and wait until it is taken.
  task automatic send_word(input logic [1:0] act, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Send the first n_bytes of a fixed header, with an optional bad signature byte.
  task automatic send_header(input logic [7:0] ver_cmd, input logic [7:0] family,
                             input logic [15:0] body_len, input int unsigned bad_pos,
                             input int unsigned n_bytes);
    logic [7:0] hdr [16];
    for (int i = 0; i < 12; i++) hdr[i] = sig_byte(4'(i));
    if (bad_pos < NoFault) hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(255, 1));
    hdr[12] = ver_cmd;
    hdr[13] = family;
    hdr[14] = body_len[15:8];
    hdr[15] = body_len[7:0];
    for (int i = 0; i < n_bytes; i++) send_word(ACT_DATA, hdr[i]);
  endtask

  task automatic send_body(input int unsigned n);
    repeat (n) send_word(ACT_DATA, 8'($urandom));
  endtask

  // Stop offering and let every expected result and the pipeline drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_level(input logic [3:0] lvl);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lvl;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One connection of the given kind, sometimes followed by a stray word.
  task automatic run_connection(input conn_e kind);
    logic [7:0]  ver_cmd;
    logic [7:0]  family;
    logic [15:0] body_len;
    logic [15:0] need_len;
    int unsigned variant;
    int unsigned bad_pos;
    ver_cmd  = {VERSION_2, CMD_PROXY};
    family   = {FAM_IPV4, 4'($urandom)};
    body_len = LEN_IPV4;
    variant  = $urandom_range(3);
    bad_pos  = NoFault;
    if (kind != CONN_NOISE) send_word(ACT_START, 8'($urandom));
    case (kind)
      CONN_IPV4: begin
        send_header(ver_cmd, family, body_len, NoFault, HeaderBytes);
        send_body(LEN_IPV4);
      end
      CONN_IPV6: begin
        family[7:4] = FAM_IPV6;
        send_header(ver_cmd, family, LEN_IPV6, NoFault, HeaderBytes);
        send_body(LEN_IPV6);
      end
      CONN_UNIX: begin
        family[7:4] = FAM_UNIX;
        send_header(ver_cmd, family, LEN_UNIX, NoFault, HeaderBytes);
        send_body(LEN_UNIX);
      end
      CONN_LOCAL: begin
        // A LOCAL header leaves its body unread, so what follows is ignored.
        ver_cmd[3:0] = CMD_LOCAL;
        send_header(ver_cmd, 8'($urandom), 16'($urandom_range(40)), NoFault, HeaderBytes);
        send_body($urandom_range(4));
      end
      CONN_OTHER: begin
        family[7:4] = (variant == 0) ? 4'h0 : 4'($urandom_range(15, 4));
        body_len    = (variant == 1) ? 16'd0 : 16'($urandom_range(24, 1));
        send_header(ver_cmd, family, body_len, NoFault, HeaderBytes);
        send_body(body_len);
      end
      CONN_BAD_HEADER: begin
        case (variant)
          0: bad_pos = $urandom_range(11);
          1: begin
            ver_cmd[7:4] = 4'($urandom);
            if (ver_cmd[7:4] == VERSION_2) ver_cmd[7] = 1'b1;
          end
          2: ver_cmd[3:0] = 4'($urandom_range(15, 2));
          default: begin
            // Known family with a length it does not allow.
            case ($urandom_range(2))
              0: begin family[7:4] = FAM_IPV4; need_len = LEN_IPV4; end
              1: begin family[7:4] = FAM_IPV6; need_len = LEN_IPV6; end
              default: begin family[7:4] = FAM_UNIX; need_len = LEN_UNIX; end
            endcase
            body_len = $urandom_range(1) ? 16'($urandom) : need_len + 16'd1;
            if (body_len == need_len) body_len = body_len ^ 16'h8000;
          end
        endcase
        send_header(ver_cmd, family, body_len, bad_pos, HeaderBytes);
        send_body($urandom_range(3));
      end
      CONN_CUT: begin
        if (variant < 2) begin
          send_header(ver_cmd, family, body_len, NoFault, $urandom_range(15));
        end else begin
          family[7:4] = (variant == 2) ? FAM_IPV4 : FAM_IPV6;
          body_len    = (variant == 2) ? LEN_IPV4 : LEN_IPV6;
          send_header(ver_cmd, family, body_len, NoFault, HeaderBytes);
          send_body($urandom_range(body_len - 1));
        end
        send_word(ACT_EOS, 8'($urandom));
      end
      default: begin
        repeat ($urandom_range(8, 1)) send_word(2'($urandom), 8'($urandom));
      end
    endcase
    if (kind != CONN_NOISE && $urandom_range(3) == 0) begin
      send_word(TailActs[$urandom_range(2)], 8'($urandom));
    end
  endtask

  // Stimulus and final verdict.
  initial begin
    int unsigned phase_no;
    int unsigned base;
    int unsigned phase_start;
    int unsigned pick;
    logic [3:0]  lvl;
    conn_e       kind;
    bit          first;
    sent         = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= LEVEL_OFF;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_START;
    data_byte_i <= 8'h00;
    calm        <= 1'b0;
    hold_reqs   <= 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner cases at the reset level, which passes connections through.
    send_word(ACT_DATA, 8'hff);
    send_word(ACT_UNUSED, 8'h00);
    send_word(ACT_EOS, 8'h00);
    send_word(ACT_START, 8'h00);
    send_word(ACT_DATA, 8'h00);
    send_word(ACT_EOS, 8'hff);

    // An unsupported level fails every connection at once.
    write_level(4'hf);
    send_word(ACT_START, 8'hff);

    // Stream ending in the middle of the fixed header.
    write_level(LEVEL_V2);
    send_word(ACT_START, 8'h00);
    send_header({VERSION_2, CMD_PROXY}, {FAM_IPV4, 4'h1}, LEN_IPV4, NoFault, 5);
    send_word(ACT_EOS, 8'h00);

    // Random phases; every third one runs at level off, then 0xf, then random levels.
    phase_no = 0;
    base     = sent;
    while (sent - base < ItemTarget) begin
      if (phase_no % 3 != 2) lvl = LEVEL_V2;
      else if (phase_no == 2) lvl = LEVEL_OFF;
      else if (phase_no == 5) lvl = 4'hf;
      else lvl = 4'($urandom);
      write_level(lvl);
      calm       <= (phase_no == 1);
      phase_start = sent;
      first       = 1'b1;
      while (sent - phase_start < ((lvl == LEVEL_V2) ? 100 : 30)) begin
        pick = $urandom_range(99);
        if (pick < 24) kind = CONN_IPV4;
        else if (pick < 44) kind = CONN_IPV6;
        else if (pick < 47) kind = CONN_UNIX;
        else if (pick < 57) kind = CONN_LOCAL;
        else if (pick < 69) kind = CONN_OTHER;
        else if (pick < 83) kind = CONN_BAD_HEADER;
        else if (pick < 93) kind = CONN_CUT;
        else kind = CONN_NOISE;
        // A Unix body under a long receiver hold-off fills the parser's queue.
        if (first && phase_no == 3) begin
          kind = CONN_UNIX;
          hold_reqs <= hold_reqs + 1;
        end
        run_connection(kind);
        first = 1'b0;
      end
      phase_no++;
    end

    settle();
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pv2hp_pkg.sv
hdl/pv2hp_front.sv
hdl/pv2hp_queue.sv
hdl/pv2hp_back.sv
hdl/proxy_v2_header_parser.sv
dv/pv2hp_checker.sv
dv/tb_top.sv
